>>> rtl/decimated_window_min_max_macros.svh
// Assertion macros for the decimated window min/max block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef DECIMATED_WINDOW_MIN_MAX_MACROS_SVH
`define DECIMATED_WINDOW_MIN_MAX_MACROS_SVH

// same-cycle implication, disabled during reset
`define DWMM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dwmm_pkg.sv
// Shared types and constants for the decimated window min/max block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dwmm_pkg;

	localparam int SAMPLE_W = 18;
	localparam int FACTOR_W = 8;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd10;
	localparam logic [SAMPLE_W-1:0] SAMPLE_ALL_ONES = '1;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} dwmm_state_t;

	// controls from the sequencer to the min/max accumulator
	typedef struct packed {
		logic clear;   // start a new scan
		logic acc_en;  // read data valid, fold it in
		logic commit;  // last read data, update window min/max
	} acc_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/decimated_window_min_max.sv
// Order: a skipped sample goes from its input beat through ST_DONE to the result register; a
// kept sample first scans the ring (one ring read per valid entry), then drains and loads.
// Only one input beat is in flight: s_tready is high only in ST_IDLE, and the load waits for a
// free result register; the single read port of the sample ring sets the scan length.
// Reset: arst_n clears phase, pointer, fill count, min/max and handshake state, and sets
// decimation_factor to 10; the ring is not cleared, only written entries are ever read.
`default_nettype none

module decimated_window_min_max
	import dwmm_pkg::*;
#(
	parameter int WINDOW_DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_wr_en,
	input  wire logic [FACTOR_W-1:0] cfg_wr_data,  // decimation_factor
	// input stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [23:0]         s_tdata,      // [17:0] sample
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [(((2*SAMPLE_W + $clog2(WINDOW_DEPTH+1)) + 7) / 8) * 8 - 1:0] m_tdata,
	// m_tdata: window_min, window_max, fill_count from bit 0 up, zero padded
	output logic                     m_tuser       // kept
);

	localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int OUT_BITS = 2*SAMPLE_W + CNT_W;
	localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8;
	localparam int PAD_W   = OUT_W - OUT_BITS;

	logic [FACTOR_W-1:0] factor_q;
	logic                result_free;
	logic                result_load;
	logic                kept;
	logic                wr_en;
	logic [PTR_W-1:0]    wr_addr;
	logic                rd_en;
	logic [PTR_W-1:0]    rd_addr;
	logic [SAMPLE_W-1:0] rd_data;
	acc_ctrl_t           acc_ctrl;
	logic [CNT_W-1:0]    fill_count;
	logic [SAMPLE_W-1:0] window_min;
	logic [SAMPLE_W-1:0] window_max;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;
	logic                m_tuser_q;

	// decimation factor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
		end else if (cfg_wr_en) begin
			factor_q <= cfg_wr_data;
		end
	end

	dwmm_ctrl #(
		.DEPTH(WINDOW_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.factor      (factor_q),
		.result_free (result_free),
		.result_load (result_load),
		.kept        (kept),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.acc_ctrl    (acc_ctrl),
		.fill_count  (fill_count)
	);

	dwmm_ring_ram #(
		.DEPTH(WINDOW_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (s_tdata[SAMPLE_W-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dwmm_minmax u_minmax (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (acc_ctrl),
		.rd_data    (rd_data),
		.window_min (window_min),
		.window_max (window_max)
	);

	// result output register
	assign result_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (result_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			m_tdata_q <= {{PAD_W{1'b0}}, fill_count, window_max, window_min};
			m_tuser_q <= kept;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// checks
	`include "decimated_window_min_max_macros.svh"

	`DWMM_ASSERT_NEXT(a_one_item_in_flight, s_tvalid && s_tready, !s_tready, "accepted a beat while busy")
	`DWMM_ASSERT_NOW(a_fill_bounded, 1'b1, fill_count <= CNT_W'(WINDOW_DEPTH), "fill count past depth")
	`DWMM_ASSERT_NOW(a_min_le_max, fill_count != '0, window_min <= window_max, "window min above max")
	`DWMM_ASSERT_NOW(a_load_when_free, result_load, result_free, "result loaded over a waiting beat")

endmodule

`default_nettype wire

>>> rtl/dwmm_ring_ram.sv
// Sample ring storage: one write port, one read port, registered read data.
// Depends on dwmm_pkg for the sample width.
`default_nettype none

module dwmm_ring_ram
	import dwmm_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [SAMPLE_W-1:0]                  wr_data,
	input  wire logic                                 rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [SAMPLE_W-1:0]                  rd_data
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/dwmm_minmax.sv
// Min/max accumulator fed by ring read data; holds the committed window bounds.
// Depends on dwmm_pkg for the control struct and sample width.
`default_nettype none

module dwmm_minmax
	import dwmm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire acc_ctrl_t           ctrl,
	input  wire logic [SAMPLE_W-1:0] rd_data,
	output logic      [SAMPLE_W-1:0] window_min,
	output logic      [SAMPLE_W-1:0] window_max
);

	logic [SAMPLE_W-1:0] lo_q, hi_q;
	logic [SAMPLE_W-1:0] lo_nxt, hi_nxt;
	logic [SAMPLE_W-1:0] min_q, max_q;

	// running bounds with the incoming word folded in
	assign lo_nxt = (rd_data < lo_q) ? rd_data : lo_q;
	assign hi_nxt = (rd_data > hi_q) ? rd_data : hi_q;

	// scan accumulators
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			lo_q <= SAMPLE_ALL_ONES;
			hi_q <= '0;
		end else if (ctrl.acc_en) begin
			lo_q <= lo_nxt;
			hi_q <= hi_nxt;
		end
	end

	// committed window bounds, zero until the first scan ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
		end else if (ctrl.commit) begin
			min_q <= lo_nxt;
			max_q <= hi_nxt;
		end
	end

	assign window_min = min_q;
	assign window_max = max_q;

endmodule

`default_nettype wire

>>> rtl/dwmm_ctrl.sv
// Sequencer: phase counter, ring pointer, fill count and the window scan.
// Depends on dwmm_pkg for the state enum, control struct and widths.
`default_nettype none

module dwmm_ctrl
	import dwmm_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [FACTOR_W-1:0]               factor,
	input  wire logic                              result_free,
	output logic                                   result_load,
	output logic                                   kept,
	output logic                                   wr_en,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	output logic                                   rd_en,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output acc_ctrl_t                              acc_ctrl,
	output logic [$clog2(DEPTH+1)-1:0]             fill_count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	dwmm_state_t state_q, state_d;

	logic [FACTOR_W-1:0] phase_q;
	logic [FACTOR_W-1:0] phase_nxt;
	logic [PTR_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic                rd_valid_s1;
	logic                kept_q;
	logic                accept;
	logic                keep;
	logic                scan_last;

	// decimation decision for the beat on the input
	assign phase_nxt = phase_q + 1'b1;
	assign keep      = (phase_nxt >= factor);
	assign accept    = in_valid && in_ready;
	assign scan_last = ((rd_idx_q + 1'b1) == count_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		wr_en           = 1'b0;
		rd_en           = 1'b0;
		result_load     = 1'b0;
		acc_ctrl.clear  = 1'b0;
		acc_ctrl.acc_en = rd_valid_s1;
		acc_ctrl.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					wr_en          = keep;
					acc_ctrl.clear = keep;
					state_d        = keep ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				acc_ctrl.commit = 1'b1;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				if (result_free) begin
					result_load = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign wr_addr         = ptr_q;
	assign rd_addr         = rd_idx_q[PTR_W-1:0];

	// phase, pointer, fill count and kept flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			ptr_q   <= '0;
			count_q <= '0;
			kept_q  <= 1'b0;
		end else if (accept) begin
			kept_q <= keep;
			if (keep) begin
				phase_q <= '0;
				ptr_q   <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
				if (count_q != CNT_FULL) begin
					count_q <= count_q + 1'b1;
				end
			end else begin
				phase_q <= phase_nxt;
			end
		end
	end

	// scan address: valid entries always sit at 0 .. count-1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	assign kept       = kept_q;
	assign fill_count = count_q;

endmodule

`default_nettype wire
